>>> rtl/emh_pkg.sv
// ----------------------------------------------------------------------------
// emh_pkg
// Shared constants, types and codes for the eight-ary min-heap engine.
// ----------------------------------------------------------------------------
package emh_pkg;

  // Heap geometry
  localparam int unsigned HEAP_CAPACITY = 1024;
  localparam int unsigned ARITY         = 8;
  localparam int unsigned ARITY_LOG     = $clog2(ARITY);
  localparam int unsigned IDX_W         = $clog2(HEAP_CAPACITY);
  localparam int unsigned CNT_W         = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned FIRST_W       = IDX_W + ARITY_LOG + 1;
  localparam int unsigned KID_W         = $clog2(ARITY + 1);

  // Item fields
  localparam int unsigned RANK_W  = 32;
  localparam int unsigned PAY_W   = 24;
  localparam int unsigned ENTRY_W = RANK_W + PAY_W;
  localparam int unsigned CMD_W   = 2;

  // Stream widths
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned S_USER_W = CMD_W;
  localparam int unsigned M_DATA_W = 72;
  localparam int unsigned M_USER_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_BUILD   = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic signed [RANK_W-1:0] rank;
    logic [PAY_W-1:0]         payload;
  } entry_t;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_LEVEL  = 11'b000_0000_0010,
    ST_SCAN   = 11'b000_0000_0100,
    ST_DECIDE = 11'b000_0000_1000,
    ST_UPLD   = 11'b000_0001_0000,
    ST_UPCHK  = 11'b000_0010_0000,
    ST_UPCMP  = 11'b000_0100_0000,
    ST_BCHK   = 11'b000_1000_0000,
    ST_BLD    = 11'b001_0000_0000,
    ST_ROOTRD = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } state_e;

endpackage

>>> rtl/emh_ram.sv
// ----------------------------------------------------------------------------
// emh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module emh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/eight_ary_min_heap_engine_unit.sv
// ----------------------------------------------------------------------------
// eight_ary_min_heap_engine_unit
// Priority queue held as an 8-ary min-heap of signed ranks with payloads.
//
//  channel  | dir | tdata (low bit up)                      | tuser
//  s_axis   | in  | key_rank[31:0], payload_index[23:0]     | command[1:0]
//  m_axis   | out | root_rank, root_payload, item_count, 0s | is_empty, op_error
//
// One command in flight at a time; s_axis_tready is high only while idle.
// Append, build on fewer than two items and refused commands go from
// acceptance straight to the root read and the report. Root commands walk
// the heap one level at a time: each level sets up the child range, reads
// each child through the single read port, waits for the registered read
// data, then decides; build runs that descent, after a parent check and a
// parent read, for every parent.
// Reset clears the item count and the sequencer; heap storage is not cleared.
// A finished result holds the sequencer until the output register is free;
// a result already waiting there does not block the next acceptance.
// ----------------------------------------------------------------------------
module eight_ary_min_heap_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key_rank[31:0], payload_index[55:32]
  input  logic [emh_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [emh_pkg::S_USER_W-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // root_rank[31:0], root_payload[55:32], item_count[66:56], zeros[71:67]
  output logic [emh_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // is_empty[0], op_error[1]
  output logic [emh_pkg::M_USER_W-1:0]  m_axis_tuser
);

  import emh_pkg::*;

  state_e             state_q, state_d;
  cmd_e               op_q, op_d;
  logic               err_q, err_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [IDX_W-1:0]   bidx_q, bidx_d;
  logic [IDX_W-1:0]   cbase_q, cbase_d;
  logic [KID_W-1:0]   cnum_q, cnum_d;
  logic [KID_W-1:0]   kid_q, kid_d;
  logic [IDX_W-1:0]   rdidx_q, rdidx_d;
  logic               pend_q, pend_d;
  logic               bestv_q, bestv_d;
  logic [IDX_W-1:0]   bld_q, bld_d;
  entry_t             cur_q, cur_d;
  entry_t             best_q, best_d;

  logic               out_valid_q, out_valid_d;
  entry_t             out_root_q, out_root_d;
  logic [CNT_W-1:0]   out_count_q, out_count_d;
  logic               out_empty_q, out_empty_d;
  logic               out_err_q, out_err_d;

  // RAM ports
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t             rdata;

  // Shared compare unit
  logic signed [RANK_W-1:0] cmp_a, cmp_b;
  logic                     cmp_lt;

  // Helpers
  logic [FIRST_W-1:0] first;
  logic [FIRST_W-1:0] avail;
  logic [CNT_W-1:0]   count_m1;
  logic [CNT_W-1:0]   bld_init;
  logic               slot_free;
  entry_t             in_entry;

  emh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_CAPACITY)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata    = entry_t'(rdata_raw);
  assign in_entry = entry_t'({s_axis_tdata[RANK_W-1:0],
                              s_axis_tdata[RANK_W+PAY_W-1:RANK_W]});

  assign first    = (FIRST_W'(pos_q) << ARITY_LOG) + FIRST_W'(1);
  assign avail    = FIRST_W'(count_q) - first;
  assign count_m1 = count_q - CNT_W'(1);
  assign bld_init = ((count_q - CNT_W'(2)) >> ARITY_LOG) + CNT_W'(1);
  assign slot_free = !out_valid_q || m_axis_tready;

  // Pick compare operands by state
  always_comb begin
    cmp_a = best_q.rank;
    cmp_b = cur_q.rank;
    unique case (state_q)
      ST_SCAN: begin
        cmp_a = rdata.rank;
        cmp_b = best_q.rank;
      end
      ST_UPCMP: begin
        cmp_a = cur_q.rank;
        cmp_b = rdata.rank;
      end
      default: begin
        cmp_a = best_q.rank;
        cmp_b = cur_q.rank;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    err_d       = err_q;
    count_d     = count_q;
    pos_d       = pos_q;
    bidx_d      = bidx_q;
    cbase_d     = cbase_q;
    cnum_d      = cnum_q;
    kid_d       = kid_q;
    rdidx_d     = rdidx_q;
    pend_d      = pend_q;
    bestv_d     = bestv_q;
    bld_d       = bld_q;
    cur_d       = cur_q;
    best_d      = best_q;
    out_valid_d = out_valid_q;
    out_root_d  = out_root_q;
    out_count_d = out_count_q;
    out_empty_d = out_empty_q;
    out_err_d   = out_err_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = cur_q;
    raddr       = '0;

    // Drop the result once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = cmd_e'(s_axis_tuser);
          err_d = 1'b0;
          unique case (cmd_e'(s_axis_tuser))
            CMD_APPEND: begin
              if (count_q == CNT_W'(HEAP_CAPACITY)) begin
                err_d = 1'b1;
              end else begin
                we      = 1'b1;
                waddr   = count_q[IDX_W-1:0];
                wdata   = in_entry;
                count_d = count_q + CNT_W'(1);
              end
              state_d = ST_ROOTRD;
            end
            CMD_BUILD: begin
              if (count_q > CNT_W'(1)) begin
                bld_d   = bld_init[IDX_W-1:0];
                state_d = ST_BCHK;
              end else begin
                state_d = ST_ROOTRD;
              end
            end
            CMD_REPLACE: begin
              if (count_q == '0) begin
                err_d   = 1'b1;
                state_d = ST_ROOTRD;
              end else begin
                cur_d   = in_entry;
                pos_d   = '0;
                state_d = ST_LEVEL;
              end
            end
            CMD_REMOVE: begin
              if (count_q == '0) begin
                err_d   = 1'b1;
                state_d = ST_ROOTRD;
              end else begin
                pos_d   = '0;
                state_d = ST_LEVEL;
              end
            end
            default: state_d = ST_ROOTRD;
          endcase
        end
      end

      // Set up the child range of the current slot, or end the descent
      ST_LEVEL: begin
        if (first < FIRST_W'(count_q)) begin
          cbase_d = first[IDX_W-1:0];
          cnum_d  = (avail >= FIRST_W'(ARITY)) ? KID_W'(ARITY) : avail[KID_W-1:0];
          kid_d   = '0;
          pend_d  = 1'b0;
          bestv_d = 1'b0;
          state_d = ST_SCAN;
        end else if (op_q == CMD_REMOVE) begin
          count_d = count_m1;
          if (CNT_W'(pos_q) == count_m1) begin
            state_d = ST_ROOTRD;
          end else begin
            raddr   = count_m1[IDX_W-1:0];
            state_d = ST_UPLD;
          end
        end else begin
          we      = 1'b1;
          state_d = (op_q == CMD_BUILD) ? ST_BCHK : ST_ROOTRD;
        end
      end

      // Stream the children through the read port and keep the minimum
      ST_SCAN: begin
        if (kid_q < cnum_q) begin
          raddr   = cbase_q + IDX_W'(kid_q);
          rdidx_d = cbase_q + IDX_W'(kid_q);
          pend_d  = 1'b1;
          kid_d   = kid_q + KID_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (!bestv_q || cmp_lt)) begin
          best_d  = rdata;
          bidx_d  = rdidx_q;
          bestv_d = 1'b1;
        end
        if (kid_q == cnum_q && !pend_q) begin
          state_d = ST_DECIDE;
        end
      end

      // Move the hole down or settle the item
      ST_DECIDE: begin
        we = 1'b1;
        if (op_q == CMD_REMOVE || cmp_lt) begin
          wdata   = best_q;
          pos_d   = bidx_q;
          state_d = ST_LEVEL;
        end else begin
          state_d = (op_q == CMD_BUILD) ? ST_BCHK : ST_ROOTRD;
        end
      end

      // Capture the last item for the sift-up
      ST_UPLD: begin
        cur_d   = rdata;
        state_d = ST_UPCHK;
      end

      ST_UPCHK: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = ST_ROOTRD;
        end else begin
          raddr   = (pos_q - IDX_W'(1)) >> ARITY_LOG;
          bidx_d  = (pos_q - IDX_W'(1)) >> ARITY_LOG;
          state_d = ST_UPCMP;
        end
      end

      ST_UPCMP: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata   = rdata;
          pos_d   = bidx_q;
          state_d = ST_UPCHK;
        end else begin
          state_d = ST_ROOTRD;
        end
      end

      // Walk the parents from the last one down to the root
      ST_BCHK: begin
        if (bld_q == '0) begin
          state_d = ST_ROOTRD;
        end else begin
          bld_d   = bld_q - IDX_W'(1);
          pos_d   = bld_q - IDX_W'(1);
          raddr   = bld_q - IDX_W'(1);
          state_d = ST_BLD;
        end
      end

      ST_BLD: begin
        cur_d   = rdata;
        state_d = ST_LEVEL;
      end

      // Read slot zero for the report
      ST_ROOTRD: begin
        state_d = ST_OUT;
      end

      // Hold until the output register is free
      ST_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_root_d  = (count_q == '0) ? '0 : rdata;
          out_count_d = count_q;
          out_empty_d = (count_q == '0);
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    err_q       <= err_d;
    pos_q       <= pos_d;
    bidx_q      <= bidx_d;
    cbase_q     <= cbase_d;
    cnum_q      <= cnum_d;
    kid_q       <= kid_d;
    rdidx_q     <= rdidx_d;
    bestv_q     <= bestv_d;
    bld_q       <= bld_d;
    cur_q       <= cur_d;
    best_q      <= best_d;
    out_root_q  <= out_root_d;
    out_count_q <= out_count_d;
    out_empty_q <= out_empty_d;
    out_err_q   <= out_err_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_DATA_W - ENTRY_W - CNT_W)'(0), out_count_q,
                          out_root_q.payload, out_root_q.rank};
  assign m_axis_tuser  = {out_err_q, out_empty_q};

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eight-ary min-heap engine. A queue of commands
// (append, build, replace root, remove root) is filled up front and streamed
// in with random gaps. Every accepted command is applied to a local copy of
// the heap, and the root report it should produce is queued. Each report the
// block returns is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_top;
  import emh_pkg::*;

  localparam logic signed [RANK_W-1:0] RANK_MIN = 32'h8000_0000;
  localparam logic signed [RANK_W-1:0] RANK_MAX = 32'h7FFF_FFFF;
  localparam int unsigned PAY_MAX = (1 << PAY_W) - 1;

  typedef struct {
    cmd_e                     cmd;
    logic signed [RANK_W-1:0] rank;
    logic [PAY_W-1:0]         pay;
  } heap_cmd_t;

  typedef struct {
    logic signed [RANK_W-1:0] rank;
    logic [PAY_W-1:0]         pay;
    logic [CNT_W-1:0]         count;
    logic                     empty;
    logic                     err;
  } root_report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // key_rank[31:0], payload_index[55:32]
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  // command[1:0]
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // root_rank[31:0], root_payload[55:32], item_count[66:56], zeros[71:67]
  logic [M_DATA_W-1:0] m_axis_tdata;
  // is_empty[0], op_error[1]
  logic [M_USER_W-1:0] m_axis_tuser;

  // Local heap image and its item count
  logic signed [RANK_W-1:0] prio_rank [HEAP_CAPACITY];
  logic [PAY_W-1:0]         prio_pay  [HEAP_CAPACITY];
  int unsigned              prio_cnt = 0;

  heap_cmd_t    cmd_q[$];
  root_report_t root_reports_q[$];
  int unsigned  gen_cnt = 0;
  int unsigned  sent_cnt = 0;
  int unsigned  fail_cnt = 0;

  eight_ary_min_heap_engine_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Heap prediction
  // --------------------------------------------------------------------------

  // Smallest child of a slot, lowest index on ties; 0 when there is none
  function automatic bit lowest_child(input int unsigned pos, output int unsigned kid);
    int unsigned first;
    int unsigned c;
    first = pos * ARITY + 1;
    if (first >= prio_cnt || first >= HEAP_CAPACITY) return 1'b0;
    kid = first;
    for (c = first + 1; c <= pos * ARITY + ARITY && c < prio_cnt; c++) begin
      if (prio_rank[c] < prio_rank[kid]) kid = c;
    end
    return 1'b1;
  endfunction

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic signed [RANK_W-1:0] r;
    logic [PAY_W-1:0]         p;
    r = prio_rank[a];
    p = prio_pay[a];
    prio_rank[a] = prio_rank[b];
    prio_pay[a]  = prio_pay[b];
    prio_rank[b] = r;
    prio_pay[b]  = p;
  endfunction

  // Push an item down while a child is strictly smaller
  function automatic void sink_from(input int unsigned pos);
    int unsigned p;
    int unsigned kid;
    p = pos;
    forever begin
      if (!lowest_child(p, kid)) break;
      if (!(prio_rank[kid] < prio_rank[p])) break;
      swap_slots(p, kid);
      p = kid;
    end
  endfunction

  // Walk the hole to a leaf, refill it with the last item and lift that item
  function automatic void pop_min();
    int unsigned hole;
    int unsigned kid;
    int unsigned parent;
    hole = 0;
    while (lowest_child(hole, kid)) begin
      prio_rank[hole] = prio_rank[kid];
      prio_pay[hole]  = prio_pay[kid];
      hole = kid;
    end
    prio_cnt--;
    if (hole == prio_cnt) return;
    prio_rank[hole] = prio_rank[prio_cnt];
    prio_pay[hole]  = prio_pay[prio_cnt];
    while (hole > 0) begin
      parent = (hole - 1) / ARITY;
      if (!(prio_rank[hole] < prio_rank[parent])) break;
      swap_slots(hole, parent);
      hole = parent;
    end
  endfunction

  function automatic root_report_t apply_heap_cmd(input cmd_e cmd,
                                                  input logic signed [RANK_W-1:0] rank,
                                                  input logic [PAY_W-1:0] pay);
    root_report_t rep;
    int unsigned  i;
    rep.err = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (prio_cnt >= HEAP_CAPACITY) begin
          rep.err = 1'b1;
        end else begin
          prio_rank[prio_cnt] = rank;
          prio_pay[prio_cnt]  = pay;
          prio_cnt++;
        end
      end
      CMD_BUILD: begin
        if (prio_cnt > 1) begin
          i = (prio_cnt - 2) / ARITY + 1;
          while (i > 0) begin
            i--;
            sink_from(i);
          end
        end
      end
      default: begin
        if (prio_cnt == 0) begin
          rep.err = 1'b1;
        end else if (cmd == CMD_REPLACE) begin
          prio_rank[0] = rank;
          prio_pay[0]  = pay;
          sink_from(0);
        end else begin
          pop_min();
        end
      end
    endcase
    rep.rank  = (prio_cnt > 0) ? prio_rank[0] : '0;
    rep.pay   = (prio_cnt > 0) ? prio_pay[0] : '0;
    rep.count = prio_cnt[CNT_W-1:0];
    rep.empty = (prio_cnt == 0);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Command generation
  // --------------------------------------------------------------------------

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Full range, a narrow band full of ties, or the extremes and near zero
  function automatic logic signed [RANK_W-1:0] rand_rank(input int unsigned style);
    case (style)
      0: return $signed($urandom);
      1: return int'($urandom_range(0, 7)) - 4;
      default: begin
        case ($urandom_range(0, 4))
          0: return RANK_MIN;
          1: return RANK_MAX;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic push_item(input cmd_e c, input logic signed [RANK_W-1:0] r,
                           input logic [PAY_W-1:0] p);
    heap_cmd_t it;
    it.cmd  = c;
    it.rank = r;
    it.pay  = p;
    cmd_q.insert(cmd_q.size(), it);
    if (c == CMD_APPEND && gen_cnt < HEAP_CAPACITY) gen_cnt++;
    if (c == CMD_REMOVE && gen_cnt > 0) gen_cnt--;
  endtask

  task automatic push_rand(input cmd_e c, input int unsigned style);
    push_item(c, rand_rank(style), PAY_W'($urandom_range(0, PAY_MAX)));
  endtask

  // Random root operation mix over an existing heap
  task automatic push_mix(input int unsigned n, input int unsigned style);
    int unsigned k;
    int unsigned r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) push_rand(CMD_REPLACE, style);
      else if (r < 75) push_rand(CMD_REMOVE, style);
      else if (r < 95) push_rand(CMD_APPEND, style);
      else push_rand(CMD_BUILD, style);
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned k;
    int unsigned style;

    // Directed: empty heap errors, trivial builds, extremes, ties, two levels
    push_item(CMD_REMOVE, 5, 24'h000001);
    push_item(CMD_REPLACE, -5, 24'h000002);
    push_item(CMD_BUILD, 0, 24'h0);
    push_item(CMD_APPEND, RANK_MAX, 24'hFFFFFF);
    push_item(CMD_BUILD, 0, 24'h0);
    push_item(CMD_APPEND, RANK_MIN, 24'h000000);
    push_item(CMD_APPEND, 0, 24'h000010);
    push_item(CMD_APPEND, -1, 24'h000011);
    push_item(CMD_APPEND, RANK_MIN, 24'h123456);
    push_item(CMD_APPEND, RANK_MAX, 24'h000013);
    push_item(CMD_APPEND, 1, 24'h000014);
    push_item(CMD_APPEND, -2, 24'h000015);
    push_item(CMD_APPEND, 100, 24'h000016);
    push_item(CMD_APPEND, 100, 24'h000017);
    push_item(CMD_APPEND, 7, 24'h000018);
    push_item(CMD_BUILD, 0, 24'h0);
    push_item(CMD_REPLACE, RANK_MAX, 24'h0000AA);
    push_item(CMD_REPLACE, RANK_MIN, 24'h0000BB);
    push_item(CMD_REMOVE, 0, 24'h0);
    push_item(CMD_REMOVE, 0, 24'h0);
    push_item(CMD_APPEND, 32'hAAAA_AAAA, 24'h555555);
    push_item(CMD_APPEND, 32'h5555_5555, 24'hAAAAAA);
    push_item(CMD_BUILD, 0, 24'h0);
    push_item(CMD_REMOVE, 0, 24'h0);

    // Small and mid-size heaps: fill, order, work the root, often drain
    while (cmd_q.size() < 440) begin
      style = $urandom_range(0, 2);
      k = $urandom_range(0, 99);
      if (k < 70) n = $urandom_range(1, 12);
      else if (k < 95) n = $urandom_range(13, 80);
      else n = $urandom_range(81, 200);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) push_rand(cmd_e'($urandom_range(0, 3)), 0);
        else push_rand(CMD_APPEND, style);
      end
      if ($urandom_range(0, 99) < 85) push_rand(CMD_BUILD, style);
      push_mix($urandom_range(1, 2 * n), style);
      if ($urandom_range(0, 1) == 1) begin
        while (gen_cnt > 0) push_rand(CMD_REMOVE, style);
        push_rand($urandom_range(0, 1) ? CMD_REMOVE : CMD_REPLACE, style);
      end
    end

    // Fill to capacity, overflow, order the full heap and work its root
    while (gen_cnt < HEAP_CAPACITY) push_rand(CMD_APPEND, $urandom_range(0, 2));
    for (k = 0; k < 3; k++) push_rand(CMD_APPEND, 0);
    push_rand(CMD_BUILD, 0);
    push_mix(40, 0);
    push_rand(CMD_REPLACE, 2);
  end

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------
  int unsigned  send_gap = 0;
  bit           offer;
  heap_cmd_t    nxt;
  root_report_t pred;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = s_axis_tvalid;
      // Predict the report for the item taken at this edge
      if (s_axis_tvalid && s_axis_tready) begin
        pred = apply_heap_cmd(cmd_e'(s_axis_tuser),
                              $signed(s_axis_tdata[RANK_W-1:0]),
                              s_axis_tdata[RANK_W+:PAY_W]);
        root_reports_q.insert(root_reports_q.size(), pred);
        sent_cnt++;
        offer = 1'b0;
        send_gap = ((sent_cnt / 128) % 4 == 1) ? 0 : idle_len();
      end
      // Present the next item once the gap has run out
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() > 0) begin
          nxt = cmd_q.pop_front();
          s_axis_tdata <= {nxt.pay, nxt.rank};
          s_axis_tuser <= nxt.cmd;
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Result acceptance: random stalls, quiet stretches, one long hold-off
  // --------------------------------------------------------------------------
  int unsigned rcv_cyc = 0;
  int unsigned sink_wait = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      rcv_cyc++;
      if (!hold_done && sent_cnt >= 300) begin
        hold_done = 1'b1;
        sink_wait = 400;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else if ((rcv_cyc / 1500) % 4 == 2) begin
        m_axis_tready <= 1'b1;
      end else begin
        sink_wait = idle_len();
        if (sink_wait == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          sink_wait--;
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  root_report_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (root_reports_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %0h tuser %0h",
                 $time, m_axis_tdata, m_axis_tuser);
        fail_cnt++;
      end else begin
        want = root_reports_q.pop_front();
        check_field("root_rank", want.rank, m_axis_tdata[RANK_W-1:0]);
        check_field("root_payload", 32'(want.pay), 32'(m_axis_tdata[RANK_W+:PAY_W]));
        check_field("item_count", 32'(want.count), 32'(m_axis_tdata[ENTRY_W+:CNT_W]));
        check_field("pad", '0, 32'(m_axis_tdata[M_DATA_W-1:ENTRY_W+CNT_W]));
        check_field("is_empty", 32'(want.empty), 32'(m_axis_tuser[0]));
        check_field("op_error", 32'(want.err), 32'(m_axis_tuser[1]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // End of run
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    while (cmd_q.size() != 0 || s_axis_tvalid || root_reports_q.size() != 0)
      @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && root_reports_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
